@@ design/decimal_accumulator_machine_step_defines.svh @@
// Assertion macros shared by the machine's RTL files.
`ifndef DECIMAL_ACCUMULATOR_MACHINE_STEP_DEFINES_SVH
`define DECIMAL_ACCUMULATOR_MACHINE_STEP_DEFINES_SVH
`ifndef ASSERT_OFF
`define DAM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define DAM_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DAM_ASSERT(label, clk, rst, prop, msg)
`define DAM_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

@@ design/dam_pkg.sv @@
// Shared types, codes and constants of the decimal accumulator machine.
`default_nettype none
package dam_pkg;
  localparam int MemWordsDefault = 16;
  localparam int ProgWords = 16;
  localparam logic [31:0] EmptyWord = 32'hFFF0BDC1;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_EXEC    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_HALT  = 3'd1;
  localparam logic [2:0] ST_VIOL  = 3'd2;
  localparam logic [2:0] ST_BADOP = 3'd3;
  localparam logic [2:0] ST_DIV0  = 3'd4;
  localparam logic [2:0] ST_END   = 3'd5;
  localparam logic [2:0] ST_IDLE  = 3'd6;

  localparam logic [6:0] I_READ = 7'd10, I_WRITE = 7'd11, I_LOAD = 7'd20,
    I_STORE = 7'd21, I_ADD = 7'd30, I_SUB = 7'd31, I_DIV = 7'd32, I_MUL = 7'd33,
    I_JMP = 7'd40, I_JNEG = 7'd41, I_JZERO = 7'd42, I_HALT = 7'd43,
    I_CLEAR = 7'd55, I_MAP = 7'd56, I_EMPTY = 7'd57, I_CLRACC = 7'd58;

  // Controller to datapath.
  typedef struct packed {
    logic capture;   // latch the request payload
    logic decode;    // fetch and decode the program word
    logic exec;      // execute the instruction when it needs no divider
    logic div_start; // start the divider
    logic div_done;  // write the quotient
    logic finish;    // register the result
  } dam_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_div;
    logic div_busy;
  } dam_stat_t;
endpackage
`default_nettype wire

@@ design/dam_ctrl.sv @@
// Controller state machine sequencing one request through the datapath.
`default_nettype none
`include "decimal_accumulator_machine_step_defines.svh"
module dam_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output dam_pkg::dam_cmd_t  cmd,
  input  wire dam_pkg::dam_stat_t stat
);
  import dam_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_EXEC   = 6'b000100,
    S_DIV    = 6'b001000,
    S_FIN    = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.is_div) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else begin
          cmd.exec = 1'b1;
          state_next = S_FIN;
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          cmd.div_done = 1'b1;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  `DAM_ASSERT(a_onehot, clk, rst, $onehot(state), "state not one-hot")
  `DAM_ASSERT(a_no_both, clk, rst, !(in_ready && out_valid), "ready while result pending")
  `DAM_ASSERT(a_div_seq, clk, rst, cmd.div_start |=> state == S_DIV, "divider not entered")
endmodule
`default_nettype wire

@@ design/dam_datapath.sv @@
// Datapath: stores, accumulator, decoder, ALU and sequential divider.
`default_nettype none
`include "decimal_accumulator_machine_step_defines.svh"
module dam_datapath #(
  parameter int MEM_WORDS = dam_pkg::MemWordsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dam_pkg::dam_cmd_t cmd,
  output dam_pkg::dam_stat_t     stat,
  input  wire logic [4:0]  program_length,
  input  wire logic [1:0]  opcode,
  input  wire logic [3:0]  load_address,
  input  wire logic [13:0] program_word,
  input  wire logic [31:0] read_value,
  output logic [4:0]       next_pc,
  output logic [31:0]      accumulator,
  output logic [31:0]      write_value,
  output logic             write_valid,
  output logic [2:0]       status
);
  import dam_pkg::*;

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  logic [13:0] prog_mem [ProgWords];
  logic [31:0] data_mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] written; // entry written since it was last emptied
  logic [MEM_WORDS-1:0] zeroed;  // entry reads zero (clear-data instruction)

  logic [1:0]  op_q;
  logic [31:0] rv_q;
  logic [31:0] acc;
  logic [4:0]  pc;
  logic        stopped;

  logic [13:0] word;
  logic [6:0]  code;
  logic [6:0]  addr;
  logic [2:0]  pre_st;  // status decided before the instruction runs
  logic        runs;
  logic [31:0] dval;

  // Word split by reciprocal multiply: word*41944 >> 22 is exact below 10000.
  logic [28:0] prod;
  logic [6:0]  quo;
  logic [13:0] rem;
  logic [4:0]  len;
  logic [31:0] mem_rd;

  assign word = prog_mem[pc[3:0]];
  assign prod = 29'(word) * 29'd41944;
  assign quo = prod[28:22];
  assign rem = word - 14'(quo) * 14'd100;
  assign len = (program_length > 5'd16) ? 5'd16 : program_length;

  logic [AW-1:0] aidx;
  assign aidx = addr[AW-1:0];
  assign mem_rd = data_mem[aidx];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= opcode; rv_q <= read_value;
    end
    if (cmd.decode) begin
      code <= quo;
      addr <= rem[6:0];
      if (op_q != OP_EXEC) begin
        pre_st <= ST_IDLE; runs <= 1'b0;
      end else if (stopped) begin
        pre_st <= ST_HALT; runs <= 1'b0;
      end else if (pc >= len) begin
        pre_st <= ST_END; runs <= 1'b0;
      end else if (rem[6:0] >= 7'(MEM_WORDS)) begin
        pre_st <= ST_VIOL; runs <= 1'b0;
      end else begin
        pre_st <= ST_OK; runs <= 1'b1;
      end
    end
  end

  always_comb begin
    if (zeroed[aidx]) dval = '0;
    else if (!written[aidx]) dval = EmptyWord;
    else dval = mem_rd;
  end

  // Shift-subtract divider on magnitudes, one quotient bit a cycle.
  logic [31:0] dv_a, dv_b, dv_q;
  logic [32:0] dv_r;
  logic [5:0]  dv_cnt;
  logic        dv_neg;
  logic [32:0] dv_trial;
  assign dv_trial = {dv_r[31:0], dv_a[31]} - {1'b0, dv_b};

  assign stat.is_div = runs && (code == I_DIV) && (dval != 32'd0);
  assign stat.div_busy = (dv_cnt != 6'd0);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dv_a <= acc[31] ? 32'(-acc) : acc;
      dv_b <= dval[31] ? 32'(-dval) : dval;
      dv_r <= '0;
      dv_q <= '0;
      dv_neg <= acc[31] ^ dval[31];
      dv_cnt <= 6'd32;
    end else if (dv_cnt != 6'd0) begin
      if (!dv_trial[32]) begin
        dv_r <= dv_trial; dv_q <= {dv_q[30:0], 1'b1};
      end else begin
        dv_r <= {dv_r[31:0], dv_a[31]}; dv_q <= {dv_q[30:0], 1'b0};
      end
      dv_a <= {dv_a[30:0], 1'b0};
      dv_cnt <= dv_cnt - 6'd1;
    end
  end

  logic [2:0]  fin_st;
  logic [31:0] fin_w;
  logic        fin_wv;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0; pc <= '0; stopped <= 1'b0; written <= '0; zeroed <= '0;
    end else begin
      if (cmd.capture && opcode == OP_LOAD) prog_mem[load_address] <= program_word;
      if (cmd.decode && op_q == OP_RESTART) begin
        pc <= '0; acc <= '0; stopped <= 1'b0; written <= '0; zeroed <= '0;
      end
      if (cmd.decode && op_q == OP_EXEC && !stopped && pc < len
          && rem[6:0] >= 7'(MEM_WORDS)) stopped <= 1'b1;
      if (cmd.div_done) begin
        acc <= dv_neg ? 32'(-dv_q) : dv_q;
        pc <= pc + 5'd1;
      end
      if (cmd.exec && runs) begin
        pc <= pc + 5'd1;
        case (code)
          I_READ: begin
            data_mem[aidx] <= rv_q; written[aidx] <= 1'b1; zeroed[aidx] <= 1'b0;
          end
          I_LOAD: acc <= dval;
          I_STORE: begin
            data_mem[aidx] <= acc; written[aidx] <= 1'b1; zeroed[aidx] <= 1'b0;
          end
          I_ADD: acc <= acc + dval;
          I_SUB: acc <= acc - dval;
          I_DIV: begin
            stopped <= 1'b1; pc <= pc;
          end
          I_MUL: acc <= 32'(acc * dval);
          I_JMP: pc <= (addr > 7'd16) ? 5'd16 : addr[4:0];
          I_JNEG: if (acc[31]) pc <= (addr > 7'd16) ? 5'd16 : addr[4:0];
          I_JZERO: if (acc == 32'd0) pc <= (addr > 7'd16) ? 5'd16 : addr[4:0];
          I_HALT: stopped <= 1'b1;
          I_CLEAR: zeroed <= '1;
          I_EMPTY: begin
            written[aidx] <= 1'b0; zeroed[aidx] <= 1'b0;
          end
          I_CLRACC: acc <= '0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec || cmd.div_done) begin
      fin_wv <= 1'b0; fin_w <= '0; fin_st <= pre_st;
      if (runs && cmd.exec) begin
        case (code)
          I_READ, I_LOAD, I_STORE, I_ADD, I_SUB, I_MUL, I_JMP, I_JNEG, I_JZERO,
          I_CLEAR, I_MAP, I_EMPTY, I_CLRACC: fin_st <= ST_OK;
          I_WRITE: begin
            fin_wv <= 1'b1; fin_w <= dval; fin_st <= ST_OK;
          end
          I_DIV: fin_st <= ST_DIV0;
          I_HALT: fin_st <= ST_HALT;
          default: fin_st <= ST_BADOP;
        endcase
      end
    end
    if (cmd.finish) begin
      next_pc <= pc; accumulator <= acc; write_value <= fin_w;
      write_valid <= fin_wv; status <= fin_st;
    end
  end

  `DAM_ASSERT(a_div_run, clk, rst, cmd.div_start |=> stat.div_busy, "divider idle after start")
  `DAM_ASSERT(a_pc_range, clk, rst, pc <= 5'd16, "pc beyond program store")
  `DAM_ASSERT(a_wv, clk, rst, cmd.finish |=> (write_valid || write_value == 32'd0), "stray write")
endmodule
`default_nettype wire

@@ design/decimal_accumulator_machine_step.sv @@
// Top level of the decimal accumulator machine.
// Each request is one load, restart or execute step and returns one result.
// From acceptance to result valid, a request passes the decode, execute and
// result register states; a divide with a nonzero divisor also waits on the
// radix-2 divider after execute. The next request is accepted in the cycle
// after the result is taken. The configuration write is always accepted and
// sets program_length.
`default_nettype none
module decimal_accumulator_machine_step #(
  parameter int MEM_WORDS = dam_pkg::MemWordsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [3:0]  load_address,
  input  wire logic [13:0] program_word,
  input  wire logic [31:0] read_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       next_pc,
  output logic [31:0]      accumulator,
  output logic [31:0]      write_value,
  output logic             write_valid,
  output logic [2:0]       status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data
);
  import dam_pkg::*;

  dam_cmd_t  cmd;
  dam_stat_t stat;
  logic [4:0] program_length;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) program_length <= '0;
    else if (cfg_valid) program_length <= cfg_data;
  end

  dam_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .stat
  );

  dam_datapath #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk, .rst, .cmd, .stat, .program_length, .opcode, .load_address,
    .program_word, .read_value, .next_pc, .accumulator, .write_value,
    .write_valid, .status
  );
endmodule
`default_nettype wire
